[hdl/cpu_alu_with_flags_core_defines.svh]
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_core_defines.svh
// Assertion macros used by the checker of the ALU core.
// ----------------------------------------------------------------------------
`ifndef CPU_ALU_WITH_FLAGS_CORE_DEFINES_SVH
`define CPU_ALU_WITH_FLAGS_CORE_DEFINES_SVH

// Checked on every rising edge outside of reset.
`define CAF_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("cpu_alu_with_flags_core: assertion failed");

// Checked on every rising edge, reset included.
`define CAF_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("cpu_alu_with_flags_core: reset assertion failed");

`endif

[hdl/cpualu_pkg.sv]
// ----------------------------------------------------------------------------
// cpualu_pkg
// Opcodes, flag codes and item layouts of the ALU core.
// ----------------------------------------------------------------------------
`default_nettype none

package cpualu_pkg;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0,
        OP_ADC = 5'd1,
        OP_SUB = 5'd2,
        OP_SBC = 5'd3,
        OP_AND = 5'd4,
        OP_OR  = 5'd5,
        OP_XOR = 5'd6,
        OP_CPL = 5'd7,
        OP_RLC = 5'd8,
        OP_RL  = 5'd9,
        OP_RRC = 5'd10,
        OP_RR  = 5'd11,
        OP_SLA = 5'd12,
        OP_SLL = 5'd13,
        OP_SRA = 5'd14,
        OP_SRL = 5'd15,
        OP_BIT = 5'd16,
        OP_SET = 5'd17,
        OP_RES = 5'd18
    } t_opcode;

    localparam logic [1:0] FLAGS_NONE  = 2'd0;
    localparam logic [1:0] FLAGS_CARRY = 2'd1;
    localparam logic [1:0] FLAGS_ALL   = 2'd2;

    typedef struct packed {
        logic [2:0]  bit_index;
        logic        carry_in;
        logic [15:0] operand_b;
        logic [15:0] operand_a;
        logic        is_word;
        logic [4:0]  opcode;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  flags_defined;
        logic        bit_is_set;
        logic        overflow_out;
        logic        half_carry_out;
        logic        carry_out;
        logic [15:0] result;
    } t_out_item;

    localparam int IN_ITEM_W  = $bits(t_in_item);
    localparam int OUT_ITEM_W = $bits(t_out_item);
    localparam int OUT_PAD_W  = OUT_TDATA_W - OUT_ITEM_W;

endpackage

`default_nettype wire

[hdl/cpu_alu_with_flags_core.sv]
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_core
// Byte and word ALU with carry, half-carry and overflow flags.
//
// Channel   Dir  Ports            Contents
// s_axis    in   tvalid/tready    one operation item
// m_axis    out  tvalid/tready    one result item
//
// Every item passes from input to output through the input register and
// then the result register, with the operation logic between.
// One item is accepted in every cycle while the output side keeps up.
// Reset is synchronous and active low; it empties both registers.
// A stalled output holds its item while the input register may still fill.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_alu_with_flags_core
    import cpualu_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // opcode, is_word, operand_a, operand_b, carry_in, bit_index, zero fill
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // result, carry_out, half_carry_out, overflow_out, bit_is_set,
    // flags_defined, zero fill
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata
);

    t_in_item  in_item;
    t_in_item  exec_in;
    t_out_item exec_out;
    t_out_item out_item;
    logic      exec_valid;
    logic      exec_ready;

    assign in_item = t_in_item'(i_s_axis_tdata[IN_ITEM_W-1:0]);

    cpualu_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_item  (in_item),
        .o_valid (exec_valid),
        .i_ready (exec_ready),
        .o_item  (exec_in)
    );

    cpualu_exec u_exec (
        .i_item (exec_in),
        .o_item (exec_out)
    );

    cpualu_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (exec_valid),
        .o_ready (exec_ready),
        .i_item  (exec_out),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_item  (out_item)
    );

    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_item};

endmodule

`default_nettype wire

[hdl/cpualu_in_stage.sv]
// ----------------------------------------------------------------------------
// cpualu_in_stage
// Input register of the ALU core with its valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module cpualu_in_stage
    import cpualu_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_ready,
    output t_in_item      o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign n_valid = o_ready ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[hdl/cpualu_exec.sv]
// ----------------------------------------------------------------------------
// cpualu_exec
// Operation logic: arithmetic, logic, shifts, rotates and bit operations.
// ----------------------------------------------------------------------------
`default_nettype none

module cpualu_exec
    import cpualu_pkg::*;
(
    input  wire t_in_item i_item,
    output t_out_item     o_item
);

    t_opcode     op;
    logic        word;
    logic [15:0] wmask;
    logic [11:0] hmask;
    logic [15:0] a_m;
    logic [15:0] b_m;
    logic [7:0]  byte_a;
    logic        cin;
    logic        is_sub;
    logic [16:0] add_full;
    logic [16:0] sub_full;
    logic [12:0] add_half;
    logic [12:0] sub_half;
    logic [15:0] arith_val;
    logic [15:0] ovf_vec;
    logic        arith_c;
    logic        arith_h;
    logic        arith_v;
    logic [7:0]  bit_sel;

    assign op     = t_opcode'(i_item.opcode);
    assign word   = i_item.is_word;
    assign wmask  = word ? 16'hffff : 16'h00ff;
    assign hmask  = word ? 12'hfff : 12'h00f;
    assign a_m    = i_item.operand_a & wmask;
    assign b_m    = i_item.operand_b & wmask;
    assign byte_a = i_item.operand_a[7:0];
    assign cin    = ((op == OP_ADC) || (op == OP_SBC)) ? i_item.carry_in : 1'b0;
    assign is_sub = (op == OP_SUB) || (op == OP_SBC);

    assign add_full = {1'b0, a_m} + {1'b0, b_m} + {16'd0, cin};
    assign sub_full = {1'b0, a_m} - {1'b0, b_m} - {16'd0, cin};
    assign add_half = {1'b0, a_m[11:0] & hmask} + {1'b0, b_m[11:0] & hmask}
                    + {12'd0, cin};
    assign sub_half = {1'b0, a_m[11:0] & hmask} - {1'b0, b_m[11:0] & hmask}
                    - {12'd0, cin};

    assign arith_val = (is_sub ? sub_full[15:0] : add_full[15:0]) & wmask;
    assign ovf_vec   = (is_sub ? (a_m ^ b_m) : ~(a_m ^ b_m)) & (a_m ^ arith_val);

    assign arith_c = is_sub ? sub_full[16] : (word ? add_full[16] : add_full[8]);
    assign arith_h = is_sub ? sub_half[12] : (word ? add_half[12] : add_half[4]);
    assign arith_v = word ? ovf_vec[15] : ovf_vec[7];

    assign bit_sel = 8'd1 << i_item.bit_index;

    always_comb begin
        o_item = '0;
        case (op)
            OP_ADD, OP_ADC, OP_SUB, OP_SBC: begin
                o_item.result         = arith_val;
                o_item.carry_out      = arith_c;
                o_item.half_carry_out = arith_h;
                o_item.overflow_out   = arith_v;
                o_item.flags_defined  = FLAGS_ALL;
            end
            OP_AND: o_item.result = (i_item.operand_a & i_item.operand_b) & wmask;
            OP_OR:  o_item.result = (i_item.operand_a | i_item.operand_b) & wmask;
            OP_XOR: o_item.result = (i_item.operand_a ^ i_item.operand_b) & wmask;
            OP_CPL: o_item.result = (~i_item.operand_a) & wmask;
            OP_RLC: begin
                o_item.result        = {8'd0, byte_a[6:0], byte_a[7]};
                o_item.carry_out     = byte_a[7];
                o_item.flags_defined = FLAGS_CARRY;
            end
            OP_RL: begin
                o_item.result        = {8'd0, byte_a[6:0], i_item.carry_in};
                o_item.carry_out     = byte_a[7];
                o_item.flags_defined = FLAGS_CARRY;
            end
            OP_RRC: begin
                o_item.result        = {8'd0, byte_a[0], byte_a[7:1]};
                o_item.carry_out     = byte_a[0];
                o_item.flags_defined = FLAGS_CARRY;
            end
            OP_RR: begin
                o_item.result        = {8'd0, i_item.carry_in, byte_a[7:1]};
                o_item.carry_out     = byte_a[0];
                o_item.flags_defined = FLAGS_CARRY;
            end
            OP_SLA: begin
                o_item.result        = {8'd0, byte_a[6:0], 1'b0};
                o_item.carry_out     = byte_a[7];
                o_item.flags_defined = FLAGS_CARRY;
            end
            OP_SLL: begin
                o_item.result        = {8'd0, byte_a[6:0], 1'b1};
                o_item.carry_out     = byte_a[7];
                o_item.flags_defined = FLAGS_CARRY;
            end
            OP_SRA: begin
                o_item.result        = {8'd0, byte_a[7], byte_a[7:1]};
                o_item.carry_out     = byte_a[0];
                o_item.flags_defined = FLAGS_CARRY;
            end
            OP_SRL: begin
                o_item.result        = {8'd0, 1'b0, byte_a[7:1]};
                o_item.carry_out     = byte_a[0];
                o_item.flags_defined = FLAGS_CARRY;
            end
            OP_BIT: begin
                o_item.result     = {8'd0, byte_a};
                o_item.bit_is_set = byte_a[i_item.bit_index];
            end
            OP_SET: o_item.result = {8'd0, byte_a | bit_sel};
            OP_RES: o_item.result = {8'd0, byte_a & ~bit_sel};
            default: o_item = '0;
        endcase
    end

endmodule

`default_nettype wire

[hdl/cpualu_out_stage.sv]
// ----------------------------------------------------------------------------
// cpualu_out_stage
// Result register of the ALU core with its valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module cpualu_out_stage
    import cpualu_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_out_item i_item,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_item
);

    logic      r_valid;
    logic      n_valid;
    t_out_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign n_valid = o_ready ? i_valid : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[hdl/cpualu_checker.sv]
// ----------------------------------------------------------------------------
// cpualu_checker
// Port-level checks of the ALU core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cpu_alu_with_flags_core_defines.svh"

module cpualu_checker
    import cpualu_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    t_out_item out_item;

    assign out_item = t_out_item'(o_m_axis_tdata[OUT_ITEM_W-1:0]);

    `CAF_ASSERT_RST(a_reset_empties, !i_rst_n |=> !o_m_axis_tvalid)

    `CAF_ASSERT(a_no_flags_clear,
        o_m_axis_tvalid && (out_item.flags_defined == FLAGS_NONE) |->
        !out_item.carry_out && !out_item.half_carry_out && !out_item.overflow_out)

    `CAF_ASSERT(a_carry_only_byte,
        o_m_axis_tvalid && (out_item.flags_defined == FLAGS_CARRY) |->
        !out_item.half_carry_out && !out_item.overflow_out &&
        (out_item.result[15:8] == 8'd0))

    `CAF_ASSERT(a_bit_test_byte,
        o_m_axis_tvalid && out_item.bit_is_set |->
        (out_item.flags_defined == FLAGS_NONE) && (out_item.result[15:8] == 8'd0))

    `CAF_ASSERT(a_stall_holds,
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata))

endmodule

bind cpu_alu_with_flags_core cpualu_checker u_cpualu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire
